FILE: rtl/tesec_pkg.sv
package tesec_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned QUERY_W = 48;
  localparam int unsigned FIELD_W = 48;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned SECS_W  = 16;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned DATA_W  = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SLOT  = 2'd0,
    CMD_EPOCH = 2'd1,
    CMD_TIME  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_GENESIS_TIME   = 3'd0,
    REG_FIRST_SLOT_S   = 3'd1,
    REG_FIRST_EPOCH_SL = 3'd2,
    REG_SECOND_EPOCH   = 3'd3,
    REG_SECOND_SLOT    = 3'd4,
    REG_SECOND_TIME    = 3'd5,
    REG_SECOND_SLOT_S  = 3'd6,
    REG_SECOND_EPOCH_SL = 3'd7
  } reg_e;

  localparam logic [TIME_W-1:0]  RST_GENESIS_TIME    = 40'd1506203091;
  localparam logic [SECS_W-1:0]  RST_FIRST_SLOT_S    = 16'd20;
  localparam logic [LEN_W-1:0]   RST_FIRST_EPOCH_SL  = 24'd21600;
  localparam logic [EPOCH_W-1:0] RST_SECOND_EPOCH    = 32'd208;
  localparam logic [FIELD_W-1:0] RST_SECOND_SLOT     = 48'd4492800;
  localparam logic [TIME_W-1:0]  RST_SECOND_TIME     = 40'd1596059091;
  localparam logic [SECS_W-1:0]  RST_SECOND_SLOT_S   = 16'd1;
  localparam logic [LEN_W-1:0]   RST_SECOND_EPOCH_SL = 24'd432000;

  // A zero divisor register behaves as one.
  function automatic logic [SECS_W-1:0] nz_secs(input logic [SECS_W-1:0] v);
    nz_secs = (v == '0) ? SECS_W'(1) : v;
  endfunction

  function automatic logic [LEN_W-1:0] nz_len(input logic [LEN_W-1:0] v);
    nz_len = (v == '0) ? LEN_W'(1) : v;
  endfunction

endpackage

FILE: rtl/tesec_div_cell.sv
module tesec_div_cell #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 16,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [VW-1:0] rem_i,
  input  logic [DW-1:0] dq_i,
  input  logic [VW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [VW-1:0] rem_o,
  output logic [DW-1:0] dq_o,
  output logic [VW-1:0] div_o,
  output logic [SW-1:0] side_o
);

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_d;
  logic [DW-1:0] dq_d;
  logic          valid_q;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] dq_q;
  logic [VW-1:0] div_q;
  logic [SW-1:0] side_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  // Quotient bits shift in at the bottom as dividend bits leave at the top.
  always_comb begin
    trial = {rem_i, dq_i[DW-1]};
    diff  = trial - {1'b0, div_i};
    ge    = (trial >= {1'b0, div_i});
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    dq_d  = {dq_i[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      dq_q   <= dq_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dq_o    = dq_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/tesec_div_chain.sv
module tesec_div_chain #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 16,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o,
  output logic [VW-1:0] divisor_o,
  output logic [SW-1:0] side_o
);

  logic          valid_s [DW+1];
  logic [VW-1:0] rem_s   [DW+1];
  logic [DW-1:0] dq_s    [DW+1];
  logic [VW-1:0] div_s   [DW+1];
  logic [SW-1:0] side_s  [DW+1];

  assign valid_s[0] = valid_i;
  assign rem_s[0]   = '0;
  assign dq_s[0]    = dividend_i;
  assign div_s[0]   = divisor_i;
  assign side_s[0]  = side_i;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    tesec_div_cell #(
      .DW(DW),
      .VW(VW),
      .SW(SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(valid_s[i]),
      .rem_i  (rem_s[i]),
      .dq_i   (dq_s[i]),
      .div_i  (div_s[i]),
      .side_i (side_s[i]),
      .valid_o(valid_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .dq_o   (dq_s[i+1]),
      .div_o  (div_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  assign valid_o   = valid_s[DW];
  assign quot_o    = dq_s[DW];
  assign rem_o     = rem_s[DW];
  assign divisor_o = div_s[DW];
  assign side_o    = side_s[DW];

endmodule

FILE: rtl/two_era_slot_epoch_converter.sv
// Slot, epoch and time converter over two eras with different slot lengths.
// Input stream: tuser carries the command (slot, epoch or Unix time), tdata
// the 48-bit query value. Every input item yields exactly one result item
// on the output stream with the slot, epoch, slot in epoch, epoch length and
// the epoch's start and end times.
// Eight era registers sit behind the APB port at byte address 8*i; they may be
// rewritten only while no item is in flight, and reset loads their defaults.
// One item is accepted per cycle while the receiver does not stall. Two chains
// of restoring divide cells, one cell per quotient bit and DW cells each, do
// the division, where DW is VALUE_WIDTH but at least 48: the first turns a
// time into a slot, the second splits the slot into epoch and offset.
// The wide multiplications use 16-bit partial products over two stages.
// When the receiver stalls, the whole pipeline holds; an empty first stage
// still takes one more item. Reset empties the pipeline at once.
module two_era_slot_epoch_converter #(
  parameter int unsigned VALUE_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [47:0] query_value
  input  logic [tesec_pkg::QUERY_W-1:0]  s_axis_tdata_i,
  // [1:0] cmd
  input  logic [tesec_pkg::CMD_W-1:0]    s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [47:0] resolved_slot, [95:48] epoch_number, [119:96] slot_in_epoch,
  // [143:120] epoch_length, [191:144] epoch_start_seconds,
  // [239:192] epoch_end_seconds
  output logic [239:0]                   m_axis_tdata_o,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [tesec_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [tesec_pkg::DATA_W-1:0]   pwdata_i,
  output logic [tesec_pkg::DATA_W-1:0]   prdata_o,
  output logic                           pready_o
);

  localparam int unsigned DW    = (VALUE_WIDTH > 48) ? VALUE_WIDTH : 48;
  localparam int unsigned NCH   = (DW + tesec_pkg::CHUNK_W - 1) / tesec_pkg::CHUNK_W;
  localparam int unsigned PADW  = NCH * tesec_pkg::CHUNK_W;
  localparam int unsigned LSW   = tesec_pkg::LEN_W + tesec_pkg::SECS_W;
  localparam int unsigned PP1W  = tesec_pkg::CHUNK_W + tesec_pkg::LEN_W;
  localparam int unsigned PP2W  = tesec_pkg::CHUNK_W + LSW;
  localparam int unsigned SW2   = DW + tesec_pkg::SECS_W + tesec_pkg::TIME_W
                                  + tesec_pkg::EPOCH_W;
  localparam logic [DW-1:0] VMASK = {DW{1'b1}} >> (DW - VALUE_WIDTH);

  // Configuration registers
  logic [tesec_pkg::TIME_W-1:0]  gen_time_q;
  logic [tesec_pkg::SECS_W-1:0]  s1_secs_q;
  logic [tesec_pkg::LEN_W-1:0]   s1_len_q;
  logic [tesec_pkg::EPOCH_W-1:0] e2_epoch_q;
  logic [tesec_pkg::FIELD_W-1:0] e2_slot_q;
  logic [tesec_pkg::TIME_W-1:0]  e2_time_q;
  logic [tesec_pkg::SECS_W-1:0]  s2_secs_q;
  logic [tesec_pkg::LEN_W-1:0]   s2_len_q;
  logic                          cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_time_q <= tesec_pkg::RST_GENESIS_TIME;
      s1_secs_q  <= tesec_pkg::RST_FIRST_SLOT_S;
      s1_len_q   <= tesec_pkg::RST_FIRST_EPOCH_SL;
      e2_epoch_q <= tesec_pkg::RST_SECOND_EPOCH;
      e2_slot_q  <= tesec_pkg::RST_SECOND_SLOT;
      e2_time_q  <= tesec_pkg::RST_SECOND_TIME;
      s2_secs_q  <= tesec_pkg::RST_SECOND_SLOT_S;
      s2_len_q   <= tesec_pkg::RST_SECOND_EPOCH_SL;
    end else if (cfg_wr) begin
      case (paddr_i[5:3])
        tesec_pkg::REG_GENESIS_TIME:    gen_time_q <= pwdata_i[tesec_pkg::TIME_W-1:0];
        tesec_pkg::REG_FIRST_SLOT_S:    s1_secs_q  <= pwdata_i[tesec_pkg::SECS_W-1:0];
        tesec_pkg::REG_FIRST_EPOCH_SL:  s1_len_q   <= pwdata_i[tesec_pkg::LEN_W-1:0];
        tesec_pkg::REG_SECOND_EPOCH:    e2_epoch_q <= pwdata_i[tesec_pkg::EPOCH_W-1:0];
        tesec_pkg::REG_SECOND_SLOT:     e2_slot_q  <= pwdata_i[tesec_pkg::FIELD_W-1:0];
        tesec_pkg::REG_SECOND_TIME:     e2_time_q  <= pwdata_i[tesec_pkg::TIME_W-1:0];
        tesec_pkg::REG_SECOND_SLOT_S:   s2_secs_q  <= pwdata_i[tesec_pkg::SECS_W-1:0];
        tesec_pkg::REG_SECOND_EPOCH_SL: s2_len_q   <= pwdata_i[tesec_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[5:3])
      tesec_pkg::REG_GENESIS_TIME:    prdata_o = tesec_pkg::DATA_W'(gen_time_q);
      tesec_pkg::REG_FIRST_SLOT_S:    prdata_o = tesec_pkg::DATA_W'(s1_secs_q);
      tesec_pkg::REG_FIRST_EPOCH_SL:  prdata_o = tesec_pkg::DATA_W'(s1_len_q);
      tesec_pkg::REG_SECOND_EPOCH:    prdata_o = tesec_pkg::DATA_W'(e2_epoch_q);
      tesec_pkg::REG_SECOND_SLOT:     prdata_o = tesec_pkg::DATA_W'(e2_slot_q);
      tesec_pkg::REG_SECOND_TIME:     prdata_o = tesec_pkg::DATA_W'(e2_time_q);
      tesec_pkg::REG_SECOND_SLOT_S:   prdata_o = tesec_pkg::DATA_W'(s2_secs_q);
      tesec_pkg::REG_SECOND_EPOCH_SL: prdata_o = tesec_pkg::DATA_W'(s2_len_q);
      default:                        prdata_o = '0;
    endcase
  end

  // Stages move together unless the output stalls; an empty stage 0 still loads.
  logic en;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic d1_valid, d2_valid;
  logic ld0;

  assign en              = !v9_q || m_axis_tready_i;
  assign ld0             = en || !v0_q;
  assign s_axis_tready_o = ld0;
  assign m_axis_tvalid_o = v9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      if (ld0) begin
        v0_q <= s_axis_tvalid_i;
      end
      if (en) begin
        v1_q <= v0_q;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= d1_valid;
        v5_q <= v4_q;
        v6_q <= d2_valid;
        v7_q <= v6_q;
        v8_q <= v7_q;
        v9_q <= v8_q;
      end
    end
  end

  // Stage 0: input register
  logic [tesec_pkg::CMD_W-1:0]   cmd0_q;
  logic [tesec_pkg::QUERY_W-1:0] val0_q;

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      cmd0_q <= s_axis_tuser_i;
      val0_q <= s_axis_tdata_i;
    end
  end

  // Stage 1: pick the era and the operands
  logic [DW-1:0]                val0_x;
  logic [DW-1:0]                dvd1_d, dvd1_q;
  logic [tesec_pkg::SECS_W-1:0] dvs1_d, dvs1_q;
  logic [DW-1:0]                add1_d, add1_q;
  logic [DW-1:0]                m1_d, m1_q;
  logic [tesec_pkg::LEN_W-1:0]  len1_d, len1_q;
  logic                         ep1_d, ep1_q;

  assign val0_x = DW'(val0_q);

  always_comb begin
    dvd1_d = val0_x;
    dvs1_d = tesec_pkg::SECS_W'(1);
    add1_d = '0;
    m1_d   = val0_x;
    len1_d = tesec_pkg::nz_len(s1_len_q);
    ep1_d  = 1'b0;
    case (cmd0_q)
      tesec_pkg::CMD_EPOCH: begin
        ep1_d = 1'b1;
        if (val0_x >= DW'(e2_epoch_q)) begin
          m1_d   = val0_x - DW'(e2_epoch_q);
          len1_d = tesec_pkg::nz_len(s2_len_q);
          add1_d = DW'(e2_slot_q);
        end
      end
      tesec_pkg::CMD_TIME: begin
        if (val0_x < DW'(e2_time_q)) begin
          // Times before genesis count as genesis.
          dvd1_d = (val0_x < DW'(gen_time_q)) ? '0 : val0_x - DW'(gen_time_q);
          dvs1_d = tesec_pkg::nz_secs(s1_secs_q);
        end else begin
          dvd1_d = val0_x - DW'(e2_time_q);
          dvs1_d = tesec_pkg::nz_secs(s2_secs_q);
          add1_d = DW'(e2_slot_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd1_q <= dvd1_d;
      dvs1_q <= dvs1_d;
      add1_q <= add1_d;
      m1_q   <= m1_d;
      len1_q <= len1_d;
      ep1_q  <= ep1_d;
    end
  end

  // Stage 2: partial products of epoch times epoch length
  logic [PADW-1:0]              m1_pad;
  logic [PP1W-1:0]              pp2_q [NCH];
  logic [DW-1:0]                dvd2_q, add2_q;
  logic [tesec_pkg::SECS_W-1:0] dvs2_q;
  logic                         ep2_q;

  assign m1_pad = PADW'(m1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NCH; k++) begin
        pp2_q[k] <= PP1W'(m1_pad[k*tesec_pkg::CHUNK_W +: tesec_pkg::CHUNK_W] * len1_q);
      end
      dvd2_q <= dvd1_q;
      add2_q <= add1_q;
      dvs2_q <= dvs1_q;
      ep2_q  <= ep1_q;
    end
  end

  // Stage 3: sum the partial products; an epoch passes the divider over one
  logic [DW-1:0]                prod3;
  logic [DW-1:0]                dvd3_q, add3_q;
  logic [tesec_pkg::SECS_W-1:0] dvs3_q;

  always_comb begin
    prod3 = '0;
    for (int k = 0; k < NCH; k++) begin
      prod3 = prod3 + (DW'(pp2_q[k]) << (k * tesec_pkg::CHUNK_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd3_q <= ep2_q ? prod3 : dvd2_q;
      add3_q <= add2_q;
      dvs3_q <= dvs2_q;
    end
  end

  // Time to slot division
  logic [DW-1:0]                d1_quot;
  logic [tesec_pkg::SECS_W-1:0] d1_rem, d1_div;
  logic [DW-1:0]                d1_add;

  tesec_div_chain #(
    .DW(DW),
    .VW(tesec_pkg::SECS_W),
    .SW(DW)
  ) u_div_time (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v3_q),
    .dividend_i(dvd3_q),
    .divisor_i (dvs3_q),
    .side_i    (add3_q),
    .valid_o   (d1_valid),
    .quot_o    (d1_quot),
    .rem_o     (d1_rem),
    .divisor_o (d1_div),
    .side_o    (d1_add)
  );

  // Stage 4: resolved slot
  logic [DW-1:0] slot4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      slot4_q <= (d1_quot + d1_add) & VMASK;
    end
  end

  // Stage 5: era of the slot
  logic [DW-1:0]                 rel5_q, slot5_q;
  logic [tesec_pkg::LEN_W-1:0]   len5_q;
  logic [tesec_pkg::SECS_W-1:0]  secs5_q;
  logic [tesec_pkg::TIME_W-1:0]  base5_q;
  logic [tesec_pkg::EPOCH_W-1:0] eoff5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      slot5_q <= slot4_q;
      if (slot4_q < DW'(e2_slot_q)) begin
        rel5_q  <= slot4_q;
        len5_q  <= tesec_pkg::nz_len(s1_len_q);
        secs5_q <= tesec_pkg::nz_secs(s1_secs_q);
        base5_q <= gen_time_q;
        eoff5_q <= '0;
      end else begin
        rel5_q  <= slot4_q - DW'(e2_slot_q);
        len5_q  <= tesec_pkg::nz_len(s2_len_q);
        secs5_q <= tesec_pkg::nz_secs(s2_secs_q);
        base5_q <= e2_time_q;
        eoff5_q <= e2_epoch_q;
      end
    end
  end

  // Slot to epoch division
  logic [DW-1:0]                 d2_quot;
  logic [tesec_pkg::LEN_W-1:0]   d2_rem, d2_len;
  logic [SW2-1:0]                d2_side;
  logic [DW-1:0]                 d2_slot;
  logic [tesec_pkg::SECS_W-1:0]  d2_secs;
  logic [tesec_pkg::TIME_W-1:0]  d2_base;
  logic [tesec_pkg::EPOCH_W-1:0] d2_eoff;

  tesec_div_chain #(
    .DW(DW),
    .VW(tesec_pkg::LEN_W),
    .SW(SW2)
  ) u_div_epoch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v5_q),
    .dividend_i(rel5_q),
    .divisor_i (len5_q),
    .side_i    ({eoff5_q, base5_q, secs5_q, slot5_q}),
    .valid_o   (d2_valid),
    .quot_o    (d2_quot),
    .rem_o     (d2_rem),
    .divisor_o (d2_len),
    .side_o    (d2_side)
  );

  assign {d2_eoff, d2_base, d2_secs, d2_slot} = d2_side;

  // Stage 6: epoch number and seconds per epoch
  logic [DW-1:0]                slot6_q, epoch6_q, ep6_q;
  logic [tesec_pkg::LEN_W-1:0]  sie6_q, len6_q;
  logic [LSW-1:0]               ls6_q;
  logic [tesec_pkg::TIME_W-1:0] base6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      slot6_q  <= d2_slot;
      epoch6_q <= (d2_quot + DW'(d2_eoff)) & VMASK;
      ep6_q    <= d2_quot;
      sie6_q   <= d2_rem;
      len6_q   <= d2_len;
      ls6_q    <= LSW'(d2_len * d2_secs);
      base6_q  <= d2_base;
    end
  end

  // Stage 7: partial products of epoch index times seconds per epoch
  logic [PADW-1:0]              ep6_pad;
  logic [PP2W-1:0]              pp7_q [NCH];
  logic [DW-1:0]                slot7_q, epoch7_q;
  logic [tesec_pkg::LEN_W-1:0]  sie7_q, len7_q;
  logic [LSW-1:0]               ls7_q;
  logic [tesec_pkg::TIME_W-1:0] base7_q;

  assign ep6_pad = PADW'(ep6_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NCH; k++) begin
        pp7_q[k] <= PP2W'(ep6_pad[k*tesec_pkg::CHUNK_W +: tesec_pkg::CHUNK_W] * ls6_q);
      end
      slot7_q  <= slot6_q;
      epoch7_q <= epoch6_q;
      sie7_q   <= sie6_q;
      len7_q   <= len6_q;
      ls7_q    <= ls6_q;
      base7_q  <= base6_q;
    end
  end

  // Stage 8: epoch start time
  logic [DW-1:0]               start8;
  logic [DW-1:0]               slot8_q, epoch8_q, start8_q;
  logic [tesec_pkg::LEN_W-1:0] sie8_q, len8_q;
  logic [LSW-1:0]              ls8_q;

  always_comb begin
    start8 = DW'(base7_q);
    for (int k = 0; k < NCH; k++) begin
      start8 = start8 + (DW'(pp7_q[k]) << (k * tesec_pkg::CHUNK_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      slot8_q  <= slot7_q;
      epoch8_q <= epoch7_q;
      sie8_q   <= sie7_q;
      len8_q   <= len7_q;
      ls8_q    <= ls7_q;
      start8_q <= start8 & VMASK;
    end
  end

  // Stage 9: output register
  logic [DW-1:0] end9;
  logic [239:0]  out9_q;

  assign end9 = (start8_q + DW'(ls8_q)) & VMASK;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out9_q <= {tesec_pkg::FIELD_W'(end9), tesec_pkg::FIELD_W'(start8_q),
                 len8_q, sie8_q,
                 tesec_pkg::FIELD_W'(epoch8_q), tesec_pkg::FIELD_W'(slot8_q)};
    end
  end

  assign m_axis_tdata_o = out9_q;

endmodule

FILE: rtl/tesec_checker.sv
module tesec_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [239:0] m_axis_tdata_o,
  input logic         pready_o
);

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_o)
    else $error("pready dropped");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[143:120] != 24'd0)
    else $error("zero epoch length");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[119:96] < m_axis_tdata_o[143:120])
    else $error("slot offset beyond epoch length");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input blocked without an output stall");

endmodule

bind two_era_slot_epoch_converter tesec_checker u_tesec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .pready_o       (pready_o)
);

FILE: dv/testbench.sv
module testbench;

  typedef struct packed {
    logic [47:0] end_secs;
    logic [47:0] start_secs;
    logic [23:0] ep_len;
    logic [23:0] slot_off;
    logic [47:0] epoch;
    logic [47:0] slot;
  } info_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [47:0] value;
  } query_t;

  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic [1:0] s_axis_tuser_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [239:0] m_axis_tdata_o;
  logic psel_i, penable_i, pwrite_i;
  logic [tesec_pkg::ADDR_W-1:0] paddr_i;
  logic [tesec_pkg::DATA_W-1:0] pwdata_i, prdata_o;
  logic pready_o;

  two_era_slot_epoch_converter DUT (.*);

  // Local copy of the era registers.
  logic [39:0] genesis_t, era2_t;
  logic [15:0] era1_secs, era2_secs;
  logic [23:0] era1_len, era2_len;
  logic [31:0] era2_epoch;
  logic [47:0] era2_slot;

  query_t pending_q[$];
  info_t  expected_q[$];
  int errors = 0;
  int accepted = 0, checked = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  // Set at the rising edge at which the current input item was taken.
  bit in_taken = 0;

  function automatic logic [63:0] nonzero(logic [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic info_t convert(logic [1:0] cmd, logic [47:0] v);
    logic [63:0] t, s, len, secs, base, rel, ep, start;
    info_t r;
    if (cmd == tesec_pkg::CMD_EPOCH) begin
      if (v < era2_epoch) s = v * nonzero(era1_len);
      else s = era2_slot + (v - era2_epoch) * nonzero(era2_len);
    end else if (cmd == tesec_pkg::CMD_TIME) begin
      t = v;
      if (t < era2_t) begin
        if (t < genesis_t) t = genesis_t;
        s = (t - genesis_t) / nonzero(era1_secs);
      end else s = era2_slot + (t - era2_t) / nonzero(era2_secs);
    end else s = v;
    s &= M48;
    if (s < era2_slot) begin
      len = nonzero(era1_len); secs = nonzero(era1_secs); base = genesis_t;
      rel = s; ep = rel / len; r.epoch = ep[47:0];
    end else begin
      len = nonzero(era2_len); secs = nonzero(era2_secs); base = era2_t;
      rel = s - era2_slot; ep = rel / len;
      r.epoch = 48'(era2_epoch + ep);
    end
    start = (base + ep * len * secs) & M48;
    r.slot = s[47:0];
    r.slot_off = 24'(rel % len);
    r.ep_len = len[23:0];
    r.start_secs = start[47:0];
    r.end_secs = 48'(start + len * secs);
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: a new item appears at a falling edge once the old one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          query_t q;
          q = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= q.cmd;
          s_axis_tdata_i <= q.value;
        end else s_axis_tvalid_i <= 1'b0;
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) begin
      expected_q.push_back(convert(s_axis_tuser_i, s_axis_tdata_i));
      accepted++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        info_t e, a;
        e = expected_q.pop_front();
        a = m_axis_tdata_o;
        checked++;
        if (a.slot !== e.slot)
          $display("%0t: slot exp %h got %h", $time, e.slot, a.slot);
        if (a.epoch !== e.epoch)
          $display("%0t: epoch exp %h got %h", $time, e.epoch, a.epoch);
        if (a.slot_off !== e.slot_off)
          $display("%0t: slot_in_epoch exp %h got %h", $time, e.slot_off, a.slot_off);
        if (a.ep_len !== e.ep_len)
          $display("%0t: epoch_length exp %h got %h", $time, e.ep_len, a.ep_len);
        if (a.start_secs !== e.start_secs)
          $display("%0t: start exp %h got %h", $time, e.start_secs, a.start_secs);
        if (a.end_secs !== e.end_secs)
          $display("%0t: end exp %h got %h", $time, e.end_secs, a.end_secs);
        if (a !== e) errors++;
      end
    end
  end

  task automatic write_reg(tesec_pkg::reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel_i <= 1; penable_i <= 0; pwrite_i <= 1;
    paddr_i <= tesec_pkg::ADDR_W'(8 * idx); pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1;
    @(negedge clk_i);
    psel_i <= 0; penable_i <= 0; pwrite_i <= 0;
    case (idx)
      tesec_pkg::REG_GENESIS_TIME:    genesis_t = val[39:0];
      tesec_pkg::REG_FIRST_SLOT_S:    era1_secs = val[15:0];
      tesec_pkg::REG_FIRST_EPOCH_SL:  era1_len = val[23:0];
      tesec_pkg::REG_SECOND_EPOCH:    era2_epoch = val[31:0];
      tesec_pkg::REG_SECOND_SLOT:     era2_slot = val[47:0];
      tesec_pkg::REG_SECOND_TIME:     era2_t = val[39:0];
      tesec_pkg::REG_SECOND_SLOT_S:   era2_secs = val[15:0];
      default:                        era2_len = val[23:0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic add(logic [1:0] cmd, logic [47:0] v);
    query_t q;
    q.cmd = cmd; q.value = v;
    pending_q.push_back(q);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // Values near the era boundaries matter most; the rest is spread widely.
  task automatic add_random(int n);
    logic [1:0] cmd;
    logic [47:0] v, pivot;
    for (int i = 0; i < n; i++) begin
      cmd = 2'($urandom_range(3));
      pivot = (cmd == tesec_pkg::CMD_EPOCH) ? 48'(era2_epoch) :
              (cmd == tesec_pkg::CMD_TIME) ?
                ($urandom_range(1) ? 48'(era2_t) : 48'(genesis_t))
              : era2_slot;
      case ($urandom_range(3))
        0: v = rand48();
        1: v = pivot + 48'($urandom_range(64)) - 48'd32;
        2: v = pivot + 48'($urandom_range(2000000)) - 48'd1000000;
        default: v = 48'($urandom());
      endcase
      add(cmd, v);
    end
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    add_random(n);
    drain();
  endtask

  initial begin
    int mode;
    s_axis_tvalid_i = 0; s_axis_tdata_i = '0; s_axis_tuser_i = '0;
    m_axis_tready_i = 0;
    psel_i = 0; penable_i = 0; pwrite_i = 0; paddr_i = '0; pwdata_i = '0;
    genesis_t = tesec_pkg::RST_GENESIS_TIME; era1_secs = tesec_pkg::RST_FIRST_SLOT_S;
    era1_len = tesec_pkg::RST_FIRST_EPOCH_SL; era2_epoch = tesec_pkg::RST_SECOND_EPOCH;
    era2_slot = tesec_pkg::RST_SECOND_SLOT; era2_t = tesec_pkg::RST_SECOND_TIME;
    era2_secs = tesec_pkg::RST_SECOND_SLOT_S; era2_len = tesec_pkg::RST_SECOND_EPOCH_SL;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: extremes, every command, the unused command, clamping.
    add(tesec_pkg::CMD_SLOT, '0); add(tesec_pkg::CMD_SLOT, M48);
    add(tesec_pkg::CMD_SLOT, era2_slot - 1); add(tesec_pkg::CMD_SLOT, era2_slot);
    add(2'd3, 48'd12345); add(2'd3, M48);
    add(tesec_pkg::CMD_EPOCH, '0); add(tesec_pkg::CMD_EPOCH, 48'd207);
    add(tesec_pkg::CMD_EPOCH, 48'd208); add(tesec_pkg::CMD_EPOCH, M48);
    add(tesec_pkg::CMD_TIME, '0); add(tesec_pkg::CMD_TIME, 48'(genesis_t));
    add(tesec_pkg::CMD_TIME, 48'(era2_t) - 1); add(tesec_pkg::CMD_TIME, 48'(era2_t));
    add(tesec_pkg::CMD_TIME, M48);
    add(tesec_pkg::CMD_TIME, 48'haaaa_aaaa_aaaa);
    add(tesec_pkg::CMD_TIME, 48'h5555_5555_5555);
    drain();

    // Pause until everything is back, then random phases per setting.
    for (int cfg = 0; cfg < 5; cfg++) begin
      if (cfg == 1) begin
        // Zero divisors behave as one.
        write_reg(tesec_pkg::REG_FIRST_SLOT_S, 0);
        write_reg(tesec_pkg::REG_FIRST_EPOCH_SL, 0);
        write_reg(tesec_pkg::REG_SECOND_SLOT_S, 0);
        write_reg(tesec_pkg::REG_SECOND_EPOCH_SL, 0);
        write_reg(tesec_pkg::REG_GENESIS_TIME, 0);
        write_reg(tesec_pkg::REG_SECOND_EPOCH, 0);
        write_reg(tesec_pkg::REG_SECOND_SLOT, 0);
        write_reg(tesec_pkg::REG_SECOND_TIME, 0);
      end else if (cfg == 2) begin
        write_reg(tesec_pkg::REG_FIRST_SLOT_S, 16'hFFFF);
        write_reg(tesec_pkg::REG_FIRST_EPOCH_SL, 24'hFFFFFF);
        write_reg(tesec_pkg::REG_SECOND_SLOT_S, 16'hFFFF);
        write_reg(tesec_pkg::REG_SECOND_EPOCH_SL, 24'hFFFFFF);
        write_reg(tesec_pkg::REG_GENESIS_TIME, 40'hFF_FFFF_FFFF);
        write_reg(tesec_pkg::REG_SECOND_EPOCH, 32'hFFFF_FFFF);
        write_reg(tesec_pkg::REG_SECOND_SLOT, M48);
        write_reg(tesec_pkg::REG_SECOND_TIME, 40'hFF_FFFF_FFFF);
      end else if (cfg >= 3) begin
        write_reg(tesec_pkg::REG_FIRST_SLOT_S, $urandom_range(1, 65535));
        write_reg(tesec_pkg::REG_FIRST_EPOCH_SL, $urandom_range(1, (1 << 24) - 1));
        write_reg(tesec_pkg::REG_SECOND_SLOT_S, $urandom_range(1, 30));
        write_reg(tesec_pkg::REG_SECOND_EPOCH_SL, $urandom_range(1, 500000));
        write_reg(tesec_pkg::REG_GENESIS_TIME, {$urandom_range(255), $urandom()});
        write_reg(tesec_pkg::REG_SECOND_EPOCH, $urandom());
        write_reg(tesec_pkg::REG_SECOND_SLOT, rand48());
        write_reg(tesec_pkg::REG_SECOND_TIME, {$urandom_range(255), $urandom()});
      end
      mode = (cfg == 0) ? 1 : 0;
      run_phase(mode ? 150 : 70, 0, 0);
      run_phase(70, 47, 0);
      run_phase(70, 0, 47);
      run_phase(70, 25, 25);
    end

    $display("Checked %0d results from %0d queries over five register settings,",
             checked, accepted);
    $display("including zero and full-scale era registers and random stalls.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: two_era_slot_epoch_converter.f
rtl/tesec_pkg.sv
rtl/tesec_div_cell.sv
rtl/tesec_div_chain.sv
rtl/two_era_slot_epoch_converter.sv
rtl/tesec_checker.sv
dv/testbench.sv
